// ===== rtl/core/frpt_pkg.sv =====
// shared constants, beat types and the angle table for the frame relative pose transform
`default_nettype none

package frpt_pkg;

    // table and cordic sizing
    localparam int MAX_FRAMES   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FIDX_W       = $clog2(MAX_FRAMES);
    localparam int FCNT_W       = $clog2(MAX_FRAMES + 1);
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // field widths
    localparam int POS_W   = 32;
    localparam int ANG_W   = 16;
    localparam int FRAME_W = 4;
    localparam int CMP_W   = (FRAME_W > FCNT_W) ? FRAME_W : FCNT_W;

    // datapath widths
    localparam int DIFF_W = POS_W + 1;
    localparam int CR_W   = 34;
    localparam int TRIG_W = 32;
    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int ACC_W  = PROD_W + 1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // shared multiplier sequence: four products plus one drain step
    localparam int MUL_W = 3;
    localparam logic [MUL_W-1:0] MUL_LAST = MUL_W'(4);

    // request codes
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_PUSH  = 1'b1;

    // fixed point constants
    localparam logic signed [CR_W-1:0] CORDIC_K0 = CR_W'(652032874);
    localparam logic signed [CR_W-1:0] ONE_Q30   = CR_W'(1073741824);
    localparam logic signed [ACC_W-1:0] HALF_Q30 = ACC_W'(536870912);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

    // atan(2^-i) as 32-bit binary angles
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        return ATAN_TAB[idx];
    endfunction

    // input beat
    typedef struct packed {
        logic                    req_type;
        logic signed [POS_W-1:0] abs_x;
        logic signed [POS_W-1:0] abs_y;
        logic signed [ANG_W-1:0] abs_heading;
        logic [FRAME_W-1:0]      frame_index;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic signed [POS_W-1:0] rel_x;
        logic signed [POS_W-1:0] rel_y;
        logic signed [ANG_W-1:0] rel_heading;
        logic [FRAME_W-1:0]      active_frame;
        logic                    table_full;
    } t_out_beat;

    // classified job handed from front to back
    typedef struct packed {
        logic                     is_query;
        logic                     table_full;
        logic [FRAME_W-1:0]       active_frame;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [ANG_W-1:0]         org_heading;
        logic [ANG_W-1:0]         rel_heading;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROT,
        B_TRIG,
        B_MUL,
        B_RND,
        B_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/core/frpt_front.sv =====
// front end: accepts request beats, keeps the frame table and forms offset jobs
`default_nettype none

module frpt_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  frpt_pkg::t_in_beat   i_in_data,
    output logic                 o_job_valid,
    input  wire                  i_job_ready,
    output frpt_pkg::t_job       o_job
);

    // frame table, entry 0 is the world origin and is never written
    logic signed [frpt_pkg::POS_W-1:0] r_mem_x [frpt_pkg::MAX_FRAMES];
    logic signed [frpt_pkg::POS_W-1:0] r_mem_y [frpt_pkg::MAX_FRAMES];
    logic [frpt_pkg::ANG_W-1:0]        r_mem_h [frpt_pkg::MAX_FRAMES];

    logic [frpt_pkg::FCNT_W-1:0] r_fiu;
    logic [frpt_pkg::FIDX_W-1:0] r_cur;
    logic [frpt_pkg::FIDX_W-1:0] n_cur;
    logic                        r_hold_valid;

    // held beat and registered table read
    logic                              r_req;
    logic                              r_full;
    logic [frpt_pkg::FRAME_W-1:0]      r_active;
    logic signed [frpt_pkg::POS_W-1:0] r_ax;
    logic signed [frpt_pkg::POS_W-1:0] r_ay;
    logic [frpt_pkg::ANG_W-1:0]        r_ah;
    logic                              r_sel_zero;
    logic signed [frpt_pkg::POS_W-1:0] r_ox;
    logic signed [frpt_pkg::POS_W-1:0] r_oy;
    logic [frpt_pkg::ANG_W-1:0]        r_oh;

    logic                              accept;
    logic                              is_push;
    logic                              tab_full;
    logic                              push_ok;
    logic                              fi_known;
    logic [frpt_pkg::FIDX_W-1:0]       sel;
    logic [frpt_pkg::FIDX_W-1:0]       push_idx;
    logic signed [frpt_pkg::POS_W-1:0] org_x;
    logic signed [frpt_pkg::POS_W-1:0] org_y;
    logic [frpt_pkg::ANG_W-1:0]        org_h;

    // classify the incoming beat
    assign o_in_ready = !r_hold_valid || i_job_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_push    = (i_in_data.req_type == frpt_pkg::REQ_PUSH);
    assign tab_full   = (r_fiu == frpt_pkg::FCNT_W'(frpt_pkg::MAX_FRAMES));
    assign push_ok    = is_push && !tab_full;
    assign push_idx   = frpt_pkg::FIDX_W'(r_fiu);
    assign fi_known   = frpt_pkg::CMP_W'(i_in_data.frame_index) < frpt_pkg::CMP_W'(r_fiu);
    assign sel        = fi_known ? frpt_pkg::FIDX_W'(i_in_data.frame_index) : r_cur;
    assign n_cur      = push_ok ? push_idx : r_cur;

    // table bookkeeping and hold valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu        <= frpt_pkg::FCNT_W'(1);
            r_cur        <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_hold_valid <= 1'b1;
                if (push_ok) begin
                    r_fiu <= r_fiu + frpt_pkg::FCNT_W'(1);
                    r_cur <= push_idx;
                end
            end else if (i_job_ready) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    // table write on push, registered read for a query
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= i_in_data.req_type;
            r_full     <= is_push && tab_full;
            r_active   <= frpt_pkg::FRAME_W'(n_cur);
            r_ax       <= i_in_data.abs_x;
            r_ay       <= i_in_data.abs_y;
            r_ah       <= i_in_data.abs_heading;
            r_sel_zero <= (sel == '0);
            r_ox       <= r_mem_x[sel];
            r_oy       <= r_mem_y[sel];
            r_oh       <= r_mem_h[sel];
            if (push_ok) begin
                r_mem_x[push_idx] <= i_in_data.abs_x;
                r_mem_y[push_idx] <= i_in_data.abs_y;
                r_mem_h[push_idx] <= i_in_data.abs_heading;
            end
        end
    end

    // offset from the chosen origin
    assign org_x = r_sel_zero ? '0 : r_ox;
    assign org_y = r_sel_zero ? '0 : r_oy;
    assign org_h = r_sel_zero ? '0 : r_oh;

    always_comb begin
        o_job.is_query     = (r_req == frpt_pkg::REQ_QUERY);
        o_job.table_full   = r_full;
        o_job.active_frame = r_active;
        o_job.dx           = frpt_pkg::DIFF_W'(r_ax) - frpt_pkg::DIFF_W'(org_x);
        o_job.dy           = frpt_pkg::DIFF_W'(r_ay) - frpt_pkg::DIFF_W'(org_y);
        o_job.org_heading  = org_h;
        o_job.rel_heading  = r_ah - org_h;
    end

    assign o_job_valid = r_hold_valid;

    // table occupancy stays sane
    a_fiu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fiu != '0) && (r_fiu <= frpt_pkg::FCNT_W'(frpt_pkg::MAX_FRAMES)))
        else $error("frames in use out of range");

    a_cur_below_fiu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frpt_pkg::CMP_W'(r_cur) < frpt_pkg::CMP_W'(r_fiu))
        else $error("current frame not stored");

endmodule

`default_nettype wire

// ===== rtl/core/frpt_queue.sv =====
// short job queue that decouples the front end from the rotation back end
`default_nettype none

module frpt_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push_valid,
    output logic             o_push_ready,
    input  frpt_pkg::t_job   i_push_data,
    output logic             o_pop_valid,
    input  wire              i_pop_ready,
    output frpt_pkg::t_job   o_pop_data
);

    frpt_pkg::t_job              r_slot [frpt_pkg::QUEUE_DEPTH];
    logic [frpt_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [frpt_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [frpt_pkg::QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != frpt_pkg::QCNT_W'(frpt_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == frpt_pkg::QPTR_W'(frpt_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + frpt_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == frpt_pkg::QPTR_W'(frpt_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + frpt_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + frpt_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - frpt_pkg::QCNT_W'(1);
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers meet only when empty or full
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue empty but pointers differ");

    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == frpt_pkg::QCNT_W'(frpt_pkg::QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue full but pointers differ");

endmodule

`default_nettype wire

// ===== rtl/core/frpt_back.sv =====
// back end: iterative cordic, shared multiplier, rounding and the output register
`default_nettype none

module frpt_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_job_valid,
    output logic                 o_job_ready,
    input  frpt_pkg::t_job       i_job,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output frpt_pkg::t_out_beat  o_out_data
);

    frpt_pkg::t_back_state r_state;
    frpt_pkg::t_back_state n_state;

    frpt_pkg::t_job                     r_job;
    logic [frpt_pkg::STEP_W-1:0]        r_step;
    logic signed [frpt_pkg::CR_W-1:0]   r_x;
    logic signed [frpt_pkg::CR_W-1:0]   r_y;
    logic signed [frpt_pkg::CR_W-1:0]   r_z;
    logic                               r_neg;
    logic signed [frpt_pkg::TRIG_W-1:0] r_cos;
    logic signed [frpt_pkg::TRIG_W-1:0] r_sin;
    logic [frpt_pkg::MUL_W-1:0]         r_k;
    logic signed [frpt_pkg::PROD_W-1:0] r_prod;
    logic signed [frpt_pkg::ACC_W-1:0]  r_acc_x;
    logic signed [frpt_pkg::ACC_W-1:0]  r_acc_y;
    frpt_pkg::t_out_beat                r_res;
    frpt_pkg::t_out_beat                r_out;
    logic                               r_out_valid;

    logic                               job_take;
    logic                               out_load;
    logic                               last_step;
    logic [31:0]                        ang;
    logic                               flip;
    logic signed [frpt_pkg::CR_W-1:0]   z0;
    logic signed [frpt_pkg::CR_W-1:0]   xs;
    logic signed [frpt_pkg::CR_W-1:0]   ys;
    logic signed [frpt_pkg::CR_W-1:0]   at;
    logic signed [frpt_pkg::CR_W-1:0]   xn;
    logic signed [frpt_pkg::CR_W-1:0]   yn;
    logic signed [frpt_pkg::CR_W-1:0]   cos_c;
    logic signed [frpt_pkg::CR_W-1:0]   sin_c;
    logic signed [frpt_pkg::DIFF_W-1:0] mul_a;
    logic signed [frpt_pkg::TRIG_W-1:0] mul_b;

    // clamp to [-1, 1] in Q1.30
    function automatic logic signed [frpt_pkg::CR_W-1:0] clamp_one(
        input logic signed [frpt_pkg::CR_W-1:0] v
    );
        if (v > frpt_pkg::ONE_Q30) begin
            return frpt_pkg::ONE_Q30;
        end else if (v < -frpt_pkg::ONE_Q30) begin
            return -frpt_pkg::ONE_Q30;
        end
        return v;
    endfunction

    // round half up at bit 30 and saturate to 32 bits
    function automatic logic signed [frpt_pkg::POS_W-1:0] scale_sat(
        input logic signed [frpt_pkg::ACC_W-1:0] acc
    );
        logic signed [frpt_pkg::ACC_W-1:0] r;
        r = (acc + frpt_pkg::HALF_Q30) >>> 30;
        if (r > frpt_pkg::SAT_HI) begin
            return frpt_pkg::POS_W'(frpt_pkg::SAT_HI);
        end else if (r < frpt_pkg::SAT_LO) begin
            return frpt_pkg::POS_W'(frpt_pkg::SAT_LO);
        end
        return frpt_pkg::POS_W'(r);
    endfunction

    assign last_step = (r_step == frpt_pkg::STEP_W'(frpt_pkg::CORDIC_STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            frpt_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.is_query ? frpt_pkg::B_ROT : frpt_pkg::B_DONE;
                end
            end
            frpt_pkg::B_ROT: begin
                if (last_step) begin
                    n_state = frpt_pkg::B_TRIG;
                end
            end
            frpt_pkg::B_TRIG: begin
                n_state = frpt_pkg::B_MUL;
            end
            frpt_pkg::B_MUL: begin
                if (r_k == frpt_pkg::MUL_LAST) begin
                    n_state = frpt_pkg::B_RND;
                end
            end
            frpt_pkg::B_RND: begin
                n_state = frpt_pkg::B_DONE;
            end
            frpt_pkg::B_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = frpt_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = frpt_pkg::B_IDLE;
            end
        endcase
    end

    // control strobes
    always_comb begin
        job_take = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            frpt_pkg::B_IDLE: job_take = i_job_valid;
            frpt_pkg::B_DONE: out_load = !r_out_valid || i_out_ready;
            default: begin
                job_take = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign o_job_ready = (r_state == frpt_pkg::B_IDLE);

    // fold the start angle into the right half plane
    always_comb begin
        ang  = {i_job.org_heading, 16'h0000};
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        z0   = frpt_pkg::CR_W'(signed'({ang[31] ^ flip, ang[30:0]}));
    end

    // one cordic micro-rotation
    assign xs = r_x >>> r_step;
    assign ys = r_y >>> r_step;
    assign at = frpt_pkg::CR_W'(frpt_pkg::atan_angle(5'(r_step)));

    // undo the fold and clamp
    assign xn    = r_neg ? -r_x : r_x;
    assign yn    = r_neg ? -r_y : r_y;
    assign cos_c = clamp_one(xn);
    assign sin_c = clamp_one(yn);

    // operand select for the shared multiplier
    assign mul_a = ((r_k == frpt_pkg::MUL_W'(0)) || (r_k == frpt_pkg::MUL_W'(3))) ?
                   r_job.dx : r_job.dy;
    assign mul_b = ((r_k == frpt_pkg::MUL_W'(0)) || (r_k == frpt_pkg::MUL_W'(2))) ?
                   r_cos : r_sin;

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frpt_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_job  <= i_job;
            r_step <= '0;
            r_x    <= frpt_pkg::CORDIC_K0;
            r_y    <= '0;
            r_z    <= z0;
            r_neg  <= flip;
            r_k    <= '0;
            r_res.rel_x        <= '0;
            r_res.rel_y        <= '0;
            r_res.rel_heading  <= '0;
            r_res.active_frame <= i_job.active_frame;
            r_res.table_full   <= i_job.table_full;
        end
        if (r_state == frpt_pkg::B_ROT) begin
            r_step <= r_step + frpt_pkg::STEP_W'(1);
            if (!r_z[frpt_pkg::CR_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
        if (r_state == frpt_pkg::B_TRIG) begin
            r_cos <= frpt_pkg::TRIG_W'(cos_c);
            r_sin <= frpt_pkg::TRIG_W'(sin_c);
        end
        if (r_state == frpt_pkg::B_MUL) begin
            r_k <= r_k + frpt_pkg::MUL_W'(1);
            if (r_k != frpt_pkg::MUL_LAST) begin
                r_prod <= mul_a * mul_b;
            end
            // accumulate the product formed one step earlier
            if (r_k == frpt_pkg::MUL_W'(1)) begin
                r_acc_x <= frpt_pkg::ACC_W'(r_prod);
            end else if (r_k == frpt_pkg::MUL_W'(2)) begin
                r_acc_x <= r_acc_x + frpt_pkg::ACC_W'(r_prod);
            end else if (r_k == frpt_pkg::MUL_W'(3)) begin
                r_acc_y <= frpt_pkg::ACC_W'(r_prod);
            end else if (r_k == frpt_pkg::MUL_LAST) begin
                r_acc_y <= r_acc_y - frpt_pkg::ACC_W'(r_prod);
            end
        end
        if (r_state == frpt_pkg::B_RND) begin
            r_res.rel_x       <= scale_sat(r_acc_x);
            r_res.rel_y       <= scale_sat(r_acc_y);
            r_res.rel_heading <= r_job.rel_heading;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // multiplier sequence only follows the trig step
    a_mul_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frpt_pkg::B_MUL && $past(r_state) != frpt_pkg::B_MUL)
        |-> $past(r_state) == frpt_pkg::B_TRIG)
        else $error("multiply entered without trig");

    // a refused push never carries a transformed pose
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.table_full)
        |-> (r_out.rel_x == '0 && r_out.rel_y == '0 && r_out.rel_heading == '0))
        else $error("refused push with nonzero pose");

endmodule

`default_nettype wire

// ===== rtl/core/frame_relative_pose_transform_top.sv =====
// top level of the frame relative pose transform
`default_nettype none

// Transforms the robot's world pose into one of up to 16 stored reference
// frames, or pushes the current pose as a new frame. Each request beat gives
// exactly one result beat, in order. For a query the back end takes the job,
// runs 16 cordic iterations (one per cycle) for the frame heading's sine and
// cosine, undoes the fold and clamps them, forms four products through one
// shared 33x32 multiplier plus a drain step, rounds, and loads the output
// register; for a push or a refused push it only takes the job and loads the
// output register. A result left waiting on the output holds the back end
// until it is taken. The front end reads or writes the frame table in the
// cycle a beat is accepted, and a two-entry job queue lets it take the next
// beat while the back end is busy.
// Frame 0 is the world origin after reset; no clearing pass is needed.

module frame_relative_pose_transform_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  frpt_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output frpt_pkg::t_out_beat  o_out_data
);

    logic           fq_valid;
    logic           fq_ready;
    frpt_pkg::t_job fq_job;
    logic           qb_valid;
    logic           qb_ready;
    frpt_pkg::t_job qb_job;

    frpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    frpt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_data   (qb_job)
    );

    frpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qb_valid),
        .o_job_ready (qb_ready),
        .i_job       (qb_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
